### hdl/bgai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-layer Green-Ampt infiltration: shared package
// Field widths, register codes and the word and stage types of the datapath.
// ----------------------------------------------------------------------------
package bgai_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DTH_W     = 17;
  localparam int unsigned EPS_W     = 16;
  localparam int unsigned FLR_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam int unsigned SD_W   = DATA_W + DTH_W - FRAC_W;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned DEN_W  = PROD_W + 1;
  localparam int unsigned NUM_W  = 3 * DATA_W;
  localparam int unsigned QUO_W  = SD_W + FRAC_W;

  localparam logic [DATA_W-1:0] TIME_STEP_RST = DATA_W'(65536);
  localparam logic [EPS_W-1:0]  CRUST_EPS_RST = EPS_W'(1);
  localparam logic [FLR_W-1:0]  VOL_FLOOR_RST = FLR_W'(66);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_CRUST_EPS = 2'd1,
    CFG_VOL_FLOOR = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KSEL_SOIL  = 2'd0,
    KSEL_CRUST = 2'd1,
    KSEL_EFF   = 2'd2
  } ksel_e;

  typedef struct packed {
    logic [DATA_W-1:0] time_step;
    logic [EPS_W-1:0]  crust_epsilon;
    logic [FLR_W-1:0]  volume_floor;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] water_height;
    logic [DATA_W-1:0] total_volume;
    logic [DATA_W-1:0] crust_conductivity;
    logic [DATA_W-1:0] soil_conductivity;
    logic [DTH_W-1:0]  moisture_deficit;
    logic [DATA_W-1:0] suction_head;
    logic [DATA_W-1:0] crust_thickness;
    logic [DATA_W-1:0] rate_cap;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_height;
    logic [DATA_W-1:0] new_total_volume;
    logic [DATA_W-1:0] capacity;
  } out_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] kc;
    logic [DATA_W-1:0] ks;
    logic [DATA_W-1:0] cap;
    logic [DATA_W-1:0] v;
    logic [SD_W-1:0]   sd;
    ksel_e             ksel;
    logic              den_zero;
  } kd_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] cap;
    logic [DATA_W-1:0] k;
  } qd_side_t;

endpackage

### hdl/bgai_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready handshake carrying one word of type T.
// ----------------------------------------------------------------------------
interface bgai_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/bgai_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; side data travels with each word.
// ----------------------------------------------------------------------------
module bgai_div #(
  parameter int unsigned DEN_BITS = 32,
  parameter int unsigned QUO_BITS = 49,
  parameter type SIDE_T = logic
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DEN_BITS-1:0] den_i,
  input  logic [DEN_BITS-1:0] rem_i,
  input  logic [QUO_BITS-1:0] lo_i,
  input  SIDE_T               side_i,
  output logic                valid_o,
  output logic [QUO_BITS-1:0] quo_o,
  output SIDE_T               side_o
);

  logic                vld_q  [QUO_BITS];
  logic [DEN_BITS-1:0] rem_q  [QUO_BITS];
  logic [DEN_BITS-1:0] den_q  [QUO_BITS];
  logic [QUO_BITS-1:0] lo_q   [QUO_BITS];
  SIDE_T               side_q [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
    logic                vld_in;
    logic [DEN_BITS-1:0] rem_in;
    logic [DEN_BITS-1:0] den_in;
    logic [QUO_BITS-1:0] lo_in;
    SIDE_T               side_in;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign lo_in   = lo_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign lo_in   = lo_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = {rem_in, lo_in[QUO_BITS-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        lo_q[i]   <= {lo_in[QUO_BITS-2:0], ge};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_BITS-1];
  assign quo_o   = lo_q[QUO_BITS-1];
  assign side_o  = side_q[QUO_BITS-1];

endmodule

### hdl/bgai_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Volume floor, suction and crust products, layer case, and the numerator
// and denominator of the effective conductivity, over four stages.
// ----------------------------------------------------------------------------
module bgai_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  bgai_pkg::in_word_t            word_i,
  input  bgai_pkg::cfg_t                cfg_i,
  output logic                          valid_o,
  output logic [bgai_pkg::NUM_W-1:0]    num_o,
  output logic [bgai_pkg::DEN_W-1:0]    den_o,
  output bgai_pkg::kd_side_t            side_o
);
  import bgai_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] kc;
    logic [DATA_W-1:0] ks;
    logic [DATA_W-1:0] cap;
    logic [DATA_W-1:0] v;
    logic [FLR_W-1:0]  floor_v;
    logic [SD_W-1:0]   sd;
    logic [SD_W-1:0]   zd;
    logic [PROD_W-1:0] kskc;
    logic              no_crust;
  } s1_t;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] kc;
    logic [DATA_W-1:0] ks;
    logic [DATA_W-1:0] cap;
    logic [DATA_W-1:0] v;
    logic [SD_W-1:0]   sd;
    logic [PROD_W-1:0] kskc;
    ksel_e             ksel;
    logic [PROD_W-1:0] da;
    logic [PROD_W-1:0] db;
  } s2_t;

  typedef struct packed {
    kd_side_t          side;
    logic [DEN_W-1:0]  den;
    logic [PROD_W-1:0] nl;
    logic [PROD_W-1:0] nh;
  } s3_t;

  typedef struct packed {
    kd_side_t         side;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num;
  } s4_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [DATA_W+DTH_W-1:0] sd_full;
  logic [DATA_W+DTH_W-1:0] zd_full;
  logic [DATA_W-1:0]       floor_ext;
  logic [SD_W:0]           front_lim;
  logic [DATA_W-1:0]       zd_lo;
  logic [DATA_W-1:0]       v_m_zd;

  always_comb begin
    s1_d.h        = word_i.water_height;
    s1_d.vt       = word_i.total_volume;
    s1_d.kc       = word_i.crust_conductivity;
    s1_d.ks       = word_i.soil_conductivity;
    s1_d.cap      = word_i.rate_cap;
    s1_d.floor_v  = (cfg_i.volume_floor == '0) ? FLR_W'(1) : cfg_i.volume_floor;
    floor_ext     = DATA_W'(s1_d.floor_v);
    s1_d.v        = (word_i.total_volume > floor_ext) ? word_i.total_volume : floor_ext;
    sd_full       = word_i.suction_head * word_i.moisture_deficit;
    zd_full       = word_i.crust_thickness * word_i.moisture_deficit;
    s1_d.sd       = sd_full[DATA_W+DTH_W-1:FRAC_W];
    s1_d.zd       = zd_full[DATA_W+DTH_W-1:FRAC_W];
    s1_d.kskc     = word_i.soil_conductivity * word_i.crust_conductivity;
    s1_d.no_crust = (word_i.crust_thickness < DATA_W'(cfg_i.crust_epsilon));
  end

  always_comb begin
    front_lim = {1'b0, s1_q.zd} + (SD_W+1)'(s1_q.floor_v);
    zd_lo     = s1_q.zd[DATA_W-1:0];
    v_m_zd    = s1_q.v - zd_lo;
    s2_d.h    = s1_q.h;
    s2_d.vt   = s1_q.vt;
    s2_d.kc   = s1_q.kc;
    s2_d.ks   = s1_q.ks;
    s2_d.cap  = s1_q.cap;
    s2_d.v    = s1_q.v;
    s2_d.sd   = s1_q.sd;
    s2_d.kskc = s1_q.kskc;
    if (s1_q.no_crust) begin
      s2_d.ksel = KSEL_SOIL;
    end else if ((SD_W+1)'(s1_q.v) <= front_lim) begin
      s2_d.ksel = KSEL_CRUST;
    end else begin
      s2_d.ksel = KSEL_EFF;
    end
    s2_d.da = s1_q.kc * v_m_zd;
    s2_d.db = s1_q.ks * zd_lo;
  end

  always_comb begin
    s3_d.side.h        = s2_q.h;
    s3_d.side.vt       = s2_q.vt;
    s3_d.side.kc       = s2_q.kc;
    s3_d.side.ks       = s2_q.ks;
    s3_d.side.cap      = s2_q.cap;
    s3_d.side.v        = s2_q.v;
    s3_d.side.sd       = s2_q.sd;
    s3_d.side.ksel     = s2_q.ksel;
    s3_d.side.den_zero = 1'b0;
    s3_d.den           = {1'b0, s2_q.da} + {1'b0, s2_q.db};
    s3_d.nl            = s2_q.kskc[DATA_W-1:0] * s2_q.v;
    s3_d.nh            = s2_q.kskc[PROD_W-1:DATA_W] * s2_q.v;
  end

  always_comb begin
    s4_d.side          = s3_q.side;
    s4_d.side.den_zero = (s3_q.den == '0);
    s4_d.den           = s3_q.den;
    s4_d.num           = {DATA_W'(0), s3_q.nl} + {s3_q.nh, DATA_W'(0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign valid_o = v4_q;
  assign num_o   = s4_q.num;
  assign den_o   = s4_q.den;
  assign side_o  = s4_q.side;

endmodule

### hdl/bgai_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate back end
// Capacity K + K*q, rate cap, volume over the time step, height limit and
// saturating totals, over four stages.
// ----------------------------------------------------------------------------
module bgai_rate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [bgai_pkg::QUO_W-1:0]    q_i,
  input  bgai_pkg::qd_side_t            side_i,
  input  logic [bgai_pkg::DATA_W-1:0]   time_step_i,
  output logic                          valid_o,
  output bgai_pkg::out_word_t           word_o
);
  import bgai_pkg::*;

  localparam int unsigned PHI_W  = DATA_W + QUO_W - DATA_W;
  localparam int unsigned P_W    = DATA_W + QUO_W;
  localparam int unsigned T_W    = P_W - FRAC_W;
  localparam int unsigned STEP_W = PROD_W - FRAC_W;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] cap;
    logic [DATA_W-1:0] k;
    logic [PROD_W-1:0] plo;
    logic [PHI_W-1:0]  phi;
  } r1_t;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] cap;
    logic [DATA_W-1:0] k;
    logic [T_W-1:0]    t;
  } r2_t;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] ic;
  } r3_t;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] vt;
    logic [DATA_W-1:0] ic;
    logic [PROD_W-1:0] prod;
  } r4_t;

  r1_t r1_d, r1_q;
  r2_t r2_d, r2_q;
  r3_t r3_d, r3_q;
  r4_t r4_d, r4_q;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [P_W-1:0]    p_full;
  logic [T_W:0]      ic_sum;
  logic [DATA_W-1:0] ic_sat;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] step_c;
  logic [DATA_W:0]   tot;

  always_comb begin
    r1_d.h   = side_i.h;
    r1_d.vt  = side_i.vt;
    r1_d.cap = side_i.cap;
    r1_d.k   = side_i.k;
    r1_d.plo = side_i.k * q_i[DATA_W-1:0];
    r1_d.phi = side_i.k * q_i[QUO_W-1:DATA_W];
  end

  always_comb begin
    p_full  = P_W'(r1_q.plo) + {r1_q.phi, DATA_W'(0)};
    r2_d.h   = r1_q.h;
    r2_d.vt  = r1_q.vt;
    r2_d.cap = r1_q.cap;
    r2_d.k   = r1_q.k;
    r2_d.t   = p_full[P_W-1:FRAC_W];
  end

  always_comb begin
    ic_sum  = (T_W+1)'(r2_q.t) + (T_W+1)'(r2_q.k);
    ic_sat  = (|ic_sum[T_W:DATA_W]) ? '1 : ic_sum[DATA_W-1:0];
    r3_d.h  = r2_q.h;
    r3_d.vt = r2_q.vt;
    r3_d.ic = (ic_sat > r2_q.cap) ? r2_q.cap : ic_sat;
  end

  always_comb begin
    r4_d.h    = r3_q.h;
    r4_d.vt   = r3_q.vt;
    r4_d.ic   = r3_q.ic;
    r4_d.prod = r3_q.ic * time_step_i;
  end

  always_comb begin
    step   = r4_q.prod[PROD_W-1:FRAC_W];
    step_c = (step > STEP_W'(r4_q.h)) ? r4_q.h : step[DATA_W-1:0];
    tot    = (DATA_W+1)'(r4_q.vt) + (DATA_W+1)'(step_c);
    word_o.new_height       = r4_q.h - step_c;
    word_o.new_total_volume = tot[DATA_W] ? '1 : tot[DATA_W-1:0];
    word_o.capacity         = r4_q.ic;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
      r4_q <= r4_d;
    end
  end

  assign valid_o = v4_q;

endmodule

### hdl/bilayer_green_ampt_infiltration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-layer Green-Ampt infiltration
// One grid cell per word: capacity, infiltrated volume, new height and total.
//
//   channel   dir   handshake          word
//   in_i      in    valid/ready        in_word_t (eight cell fields)
//   out_o     out   valid/ready        out_word_t (height, total, capacity)
//   cfg       in    cfg_we_i, no wait  cfg_idx_i selects, cfg_data_i
//
// One word per cycle unless the output stalls; words pass the 32-stage
// conductivity divider and the 49-stage suction divider in series.
// Reset clears all valid bits and loads the register defaults.
// A stalled output word fills a skid register; the pipeline then holds
// until the skid drains. Input ready depends only on that register.
// ----------------------------------------------------------------------------
module bilayer_green_ampt_infiltration (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bgai_stream_if.sink                      in_i,
  bgai_stream_if.source                    out_o,
  input  logic                             cfg_we_i,
  input  logic [bgai_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bgai_pkg::CFG_W-1:0]       cfg_data_i
);
  import bgai_pkg::*;

  cfg_t cfg_q;

  logic             pipe_en;
  logic             fr_valid;
  logic [NUM_W-1:0] fr_num;
  logic [DEN_W-1:0] fr_den;
  kd_side_t         fr_side;

  logic              kd_valid;
  logic [DATA_W-1:0] kd_quo;
  kd_side_t          kd_side;
  qd_side_t          qd_in;

  logic              qd_valid;
  logic [QUO_W-1:0]  qd_quo;
  qd_side_t          qd_side;

  logic      rate_valid;
  out_word_t rate_word;

  logic      out_valid_q, skid_valid_q;
  out_word_t out_q, skid_q;
  logic      rate_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step     <= TIME_STEP_RST;
      cfg_q.crust_epsilon <= CRUST_EPS_RST;
      cfg_q.volume_floor  <= VOL_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_STEP: cfg_q.time_step     <= cfg_data_i[DATA_W-1:0];
        CFG_CRUST_EPS: cfg_q.crust_epsilon <= cfg_data_i[EPS_W-1:0];
        CFG_VOL_FLOOR: cfg_q.volume_floor  <= cfg_data_i[FLR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pipe_en    = !skid_valid_q;
  assign in_i.ready = pipe_en;

  bgai_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_i.valid),
    .word_i  (in_i.data),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .num_o   (fr_num),
    .den_o   (fr_den),
    .side_o  (fr_side)
  );

  bgai_div #(
    .DEN_BITS (DEN_W),
    .QUO_BITS (DATA_W),
    .SIDE_T   (kd_side_t)
  ) u_kdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fr_valid),
    .den_i   (fr_den),
    .rem_i   ({1'b0, fr_num[NUM_W-1:DATA_W]}),
    .lo_i    (fr_num[DATA_W-1:0]),
    .side_i  (fr_side),
    .valid_o (kd_valid),
    .quo_o   (kd_quo),
    .side_o  (kd_side)
  );

  always_comb begin
    qd_in.h   = kd_side.h;
    qd_in.vt  = kd_side.vt;
    qd_in.cap = kd_side.cap;
    case (kd_side.ksel)
      KSEL_SOIL:  qd_in.k = kd_side.ks;
      KSEL_CRUST: qd_in.k = kd_side.kc;
      KSEL_EFF:   qd_in.k = kd_side.den_zero ? '0 : kd_quo;
      default:    qd_in.k = '0;
    endcase
  end

  bgai_div #(
    .DEN_BITS (DATA_W),
    .QUO_BITS (QUO_W),
    .SIDE_T   (qd_side_t)
  ) u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (kd_valid),
    .den_i   (kd_side.v),
    .rem_i   ('0),
    .lo_i    ({kd_side.sd, FRAC_W'(0)}),
    .side_i  (qd_in),
    .valid_o (qd_valid),
    .quo_o   (qd_quo),
    .side_o  (qd_side)
  );

  bgai_rate u_rate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (qd_valid),
    .q_i         (qd_quo),
    .side_i      (qd_side),
    .time_step_i (cfg_q.time_step),
    .valid_o     (rate_valid),
    .word_o      (rate_word)
  );

  assign rate_take = rate_valid && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= rate_take;
      end
    end else if (rate_take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_q <= skid_valid_q ? skid_q : rate_word;
    end else if (rate_take) begin
      skid_q <= rate_word;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_o.ready))
    else $error("skid filled while output was free");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_en && rate_valid) |=> rate_valid)
    else $error("pipeline word lost during stall");
`endif

endmodule
